@@ sv/pame_pkg.sv @@
// ----------------------------------------------------------------------------
// pame_pkg
// Shared types, widths and codes of the polynomial add/multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pame_pkg;

  localparam int STORE_DEPTH    = 32;
  localparam int IDX_W          = 5;
  localparam int OP_W           = 3;
  localparam int IN_W           = 16;
  localparam int COEF_W         = 24;
  localparam int PROD_W         = 2 * COEF_W;
  localparam int ACC_W          = 54;
  localparam int RES_W          = 52;
  localparam int REXP_W         = 6;
  localparam int DEF_MAX_DEGREE = 31;
  localparam int QUEUE_DEPTH    = 2;

  // request operation codes
  localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd4;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_CLEAR,
    CMD_ADD,
    CMD_MUL,
    CMD_RANGE_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [IN_W-1:0]   coef;
    logic [IDX_W-1:0]         idx;
  } cmd_t;

  // clamp a load sum to the store range
  function automatic logic signed [COEF_W-1:0] sat_coef(logic signed [COEF_W:0] v);
    logic signed [COEF_W:0] hi;
    logic signed [COEF_W:0] lo;
    hi = (COEF_W+1)'(2**(COEF_W-1) - 1);
    lo = -(COEF_W+1)'(2**(COEF_W-1));
    if (v > hi) return {1'b0, {(COEF_W-1){1'b1}}};
    if (v < lo) return {1'b1, {(COEF_W-1){1'b0}}};
    return v[COEF_W-1:0];
  endfunction

  // clamp an accumulated product to the result range
  function automatic logic signed [RES_W-1:0] sat_res(logic signed [ACC_W-1:0] v);
    logic all0;
    logic all1;
    all0 = ~|v[ACC_W-1:RES_W-1];
    all1 = &v[ACC_W-1:RES_W-1];
    if (all0 || all1) return v[RES_W-1:0];
    if (v[ACC_W-1]) return {1'b1, {(RES_W-1){1'b0}}};
    return {1'b0, {(RES_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

@@ sv/polynomial_add_multiply_engine.sv @@
// Flow: a taken request enters the command queue and is popped once the back end is idle;
// a load or clear then takes effect in the stores, a range error in the result register,
// and an add steps the exponent down from MAX_DEGREE. Multiply runs each exponent down
// from 2*MAX_DEGREE through one shared 24x24 multiplier stepping over the stored terms.
// Throughput: one request per run; a two-entry queue takes two more meanwhile, and
// the receiver cannot stall. Reset (rst_n low, synchronous) zeroes stores and queue.
// ----------------------------------------------------------------------------
// polynomial_add_multiply_engine
// Two dense coefficient stores with load, clear, add and multiply requests.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_add_multiply_engine
  import pame_pkg::*;
#(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          in_operation,
  input  wire logic signed [IN_W-1:0]   in_coefficient,
  input  wire logic signed [IN_W-1:0]   in_exponent,
  output logic                          out_valid,
  output logic signed [RES_W-1:0]       out_result_coefficient,
  output logic [REXP_W-1:0]             out_result_exponent,
  output logic                          out_last_term,
  output logic                          out_empty_result,
  output logic                          out_range_error
);

  cmd_t dec_cmd;
  cmd_t head_cmd;
  logic dec_valid;
  logic q_full;
  logic q_avail;
  logic q_pop;

  assign busy = q_full;

  // request decode
  pame_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
    .operation   (in_operation),
    .coefficient (in_coefficient),
    .exponent    (in_exponent),
    .cmd         (dec_cmd),
    .cmd_valid   (dec_valid)
  );

  // command queue
  pame_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !q_full && dec_valid),
    .push_cmd  (dec_cmd),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .not_empty (q_avail),
    .full      (q_full)
  );

  // execution
  pame_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head_cmd),
    .cmd_avail (q_avail),
    .cmd_pop   (q_pop),
    .res_valid (out_valid),
    .res_coef  (out_result_coefficient),
    .res_exp   (out_result_exponent),
    .res_last  (out_last_term),
    .res_empty (out_empty_result),
    .res_err   (out_range_error)
  );

endmodule

`default_nettype wire

@@ sv/pame_front.sv @@
// ----------------------------------------------------------------------------
// pame_front
// Decodes an incoming request into a command and checks the load exponent.
// ----------------------------------------------------------------------------
`default_nettype none

module pame_front
  import pame_pkg::*;
#(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  wire logic [OP_W-1:0]        operation,
  input  wire logic signed [IN_W-1:0] coefficient,
  input  wire logic signed [IN_W-1:0] exponent,
  output cmd_t                        cmd,
  output logic                        cmd_valid
);

  logic in_range;

  // exponent must lie in 0..MAX_DEGREE
  assign in_range = (exponent >= $signed(IN_W'(0))) &&
                    (exponent <= $signed(IN_W'(MAX_DEGREE)));

  // classify
  always_comb begin
    cmd.coef  = coefficient;
    cmd.idx   = exponent[IDX_W-1:0];
    cmd.kind  = CMD_CLEAR;
    cmd_valid = 1'b1;
    unique case (operation)
      OP_LOAD_A: cmd.kind = in_range ? CMD_LOAD_A : CMD_RANGE_ERR;
      OP_LOAD_B: cmd.kind = in_range ? CMD_LOAD_B : CMD_RANGE_ERR;
      OP_CLEAR:  cmd.kind = CMD_CLEAR;
      OP_ADD:    cmd.kind = CMD_ADD;
      OP_MUL:    cmd.kind = CMD_MUL;
      default:   cmd_valid = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/pame_queue.sv @@
// ----------------------------------------------------------------------------
// pame_queue
// Short command queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pame_queue
  import pame_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      not_empty,
  output logic      full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_cmd  = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

@@ sv/pame_back.sv @@
// ----------------------------------------------------------------------------
// pame_back
// Holds both operand stores and carries out loads, clear, add and multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module pame_back
  import pame_pkg::*;
#(
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  input  wire logic                   cmd_avail,
  output logic                        cmd_pop,
  output logic                        res_valid,
  output logic signed [RES_W-1:0]     res_coef,
  output logic [REXP_W-1:0]           res_exp,
  output logic                        res_last,
  output logic                        res_empty,
  output logic                        res_err
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADD    = 6'b000010,
    S_MUL    = 6'b000100,
    S_MDRAIN = 6'b001000,
    S_MEVAL  = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [COEF_W-1:0] a_r [STORE_DEPTH];
  logic signed [COEF_W-1:0] b_r [STORE_DEPTH];

  logic [IDX_W-1:0]          i_r;
  logic [REXP_W-1:0]         k_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic                      pend_v_r;
  logic signed [RES_W-1:0]   pend_coef_r;
  logic [REXP_W-1:0]         pend_exp_r;

  logic                      out_v_r;
  logic signed [RES_W-1:0]   out_coef_r;
  logic [REXP_W-1:0]         out_exp_r;
  logic                      out_last_r;
  logic                      out_empty_r;
  logic                      out_err_r;

  logic signed [COEF_W:0]    load_sum;
  logic signed [COEF_W:0]    add_sum;
  logic [REXP_W:0]           j_full;
  logic                      j_ok;
  logic signed [COEF_W-1:0]  b_sel;
  logic                      term_v;
  logic signed [RES_W-1:0]   term_coef;
  logic [REXP_W-1:0]         term_exp;

  assign cmd_pop = (state_r == S_IDLE) && cmd_avail;

  // load sum into the chosen store
  assign load_sum = (cmd.kind == CMD_LOAD_A) ?
                    ($signed({a_r[cmd.idx][COEF_W-1], a_r[cmd.idx]}) + (COEF_W+1)'(cmd.coef)) :
                    ($signed({b_r[cmd.idx][COEF_W-1], b_r[cmd.idx]}) + (COEF_W+1)'(cmd.coef));

  // sum term at exponent k
  assign add_sum = $signed({a_r[k_r[IDX_W-1:0]][COEF_W-1], a_r[k_r[IDX_W-1:0]]}) +
                   $signed({b_r[k_r[IDX_W-1:0]][COEF_W-1], b_r[k_r[IDX_W-1:0]]});

  // partner index j = k - i for the product term
  assign j_full = {1'b0, k_r} - (REXP_W+1)'(i_r);
  assign j_ok   = !j_full[REXP_W] && (j_full[REXP_W-1:0] <= REXP_W'(MAX_DEGREE));
  assign b_sel  = j_ok ? b_r[j_full[IDX_W-1:0]] : '0;

  // candidate term of this cycle
  always_comb begin
    term_v    = 1'b0;
    term_coef = '0;
    term_exp  = k_r;
    if (state_r == S_ADD) begin
      term_coef = RES_W'(add_sum);
      term_v    = (add_sum != '0);
    end else if (state_r == S_MEVAL) begin
      term_coef = sat_res(acc_r);
      term_v    = (term_coef != '0);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_avail && cmd.kind == CMD_ADD) state_nxt = S_ADD;
        else if (cmd_avail && cmd.kind == CMD_MUL) state_nxt = S_MUL;
      end
      S_ADD:    if (k_r == '0) state_nxt = S_FIN;
      S_MUL:    if (i_r == IDX_W'(MAX_DEGREE)) state_nxt = S_MDRAIN;
      S_MDRAIN: state_nxt = S_MEVAL;
      S_MEVAL:  state_nxt = (k_r == '0) ? S_FIN : S_MUL;
      S_FIN:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // operand stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < STORE_DEPTH; n++) begin
        a_r[n] <= '0;
        b_r[n] <= '0;
      end
    end else if (cmd_pop) begin
      case (cmd.kind)
        CMD_LOAD_A: a_r[cmd.idx] <= sat_coef(load_sum);
        CMD_LOAD_B: b_r[cmd.idx] <= sat_coef(load_sum);
        CMD_CLEAR: begin
          for (int n = 0; n < STORE_DEPTH; n++) begin
            a_r[n] <= '0;
            b_r[n] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // counters and multiply-accumulate
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        i_r    <= '0;
        prod_r <= '0;
        acc_r  <= '0;
        k_r    <= (cmd.kind == CMD_MUL) ? REXP_W'(2 * MAX_DEGREE) : REXP_W'(MAX_DEGREE);
      end
      S_ADD: k_r <= k_r - 1'b1;
      S_MUL: begin
        prod_r <= a_r[i_r] * b_sel;
        acc_r  <= acc_r + ACC_W'(prod_r);
        i_r    <= i_r + 1'b1;
      end
      S_MDRAIN: begin
        acc_r  <= acc_r + ACC_W'(prod_r);
        prod_r <= '0;
      end
      S_MEVAL: begin
        acc_r <= '0;
        i_r   <= '0;
        k_r   <= k_r - 1'b1;
      end
      default: ;
    endcase
  end

  // pending term and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_v_r <= 1'b0;
      if (cmd_pop) begin
        pend_v_r <= 1'b0;
        if (cmd.kind == CMD_RANGE_ERR) begin
          out_v_r     <= 1'b1;
          out_coef_r  <= '0;
          out_exp_r   <= '0;
          out_last_r  <= 1'b1;
          out_empty_r <= 1'b0;
          out_err_r   <= 1'b1;
        end
      end else if (term_v) begin
        pend_v_r    <= 1'b1;
        pend_coef_r <= term_coef;
        pend_exp_r  <= term_exp;
        if (pend_v_r) begin
          out_v_r     <= 1'b1;
          out_coef_r  <= pend_coef_r;
          out_exp_r   <= pend_exp_r;
          out_last_r  <= 1'b0;
          out_empty_r <= 1'b0;
          out_err_r   <= 1'b0;
        end
      end else if (state_r == S_FIN) begin
        pend_v_r    <= 1'b0;
        out_v_r     <= 1'b1;
        out_coef_r  <= pend_v_r ? pend_coef_r : '0;
        out_exp_r   <= pend_v_r ? pend_exp_r : '0;
        out_last_r  <= 1'b1;
        out_empty_r <= !pend_v_r;
        out_err_r   <= 1'b0;
      end
    end
  end

  assign res_valid = out_v_r;
  assign res_coef  = out_coef_r;
  assign res_exp   = out_exp_r;
  assign res_last  = out_last_r;
  assign res_empty = out_empty_r;
  assign res_err   = out_err_r;

  // an empty result carries no term
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_empty_r |-> out_last_r && out_coef_r == '0 && !out_err_r)
    else $error("empty result carries a term");

  // a term result is never zero
  a_term_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_empty_r && !out_err_r |-> out_coef_r != '0)
    else $error("zero term emitted");

  // the closing step always delivers the final item
  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> state_r == S_IDLE && out_v_r && out_last_r)
    else $error("run closed without final item");

endmodule

`default_nettype wire
